>>> rtl/core/jfs_pkg.sv
// ----------------------------------------------------------------------------
// jfs_pkg
// Types and constants shared by the JPEG frame size scanner modules.
// ----------------------------------------------------------------------------
package jfs_pkg;

    // Parse phase of the marker walker
    typedef enum logic [3:0] {
        PH_MARK_HI = 4'd0,
        PH_MARK_LO = 4'd1,
        PH_LEN_HI  = 4'd2,
        PH_LEN_LO  = 4'd3,
        PH_SKIP    = 4'd4,
        PH_PREC    = 4'd5,
        PH_HGT_HI  = 4'd6,
        PH_HGT_LO  = 4'd7,
        PH_WID_HI  = 4'd8,
        PH_WID_LO  = 4'd9,
        PH_DONE    = 4'd10
    } phase_t;

    // Result status codes
    typedef enum logic [2:0] {
        ST_FOUND     = 3'd0,
        ST_BAD_MARK  = 3'd1,
        ST_EOI       = 3'd2,
        ST_BAD_LEN   = 3'd3,
        ST_TRUNCATED = 3'd4
    } status_t;

    localparam logic [15:0] M_SOI  = 16'hffd8;
    localparam logic [15:0] M_SOF0 = 16'hffc0;
    localparam logic [15:0] M_SOF2 = 16'hffc2;
    localparam logic [15:0] M_RST0 = 16'hffd0;
    localparam logic [15:0] M_RST7 = 16'hffd7;
    localparam logic [15:0] M_EOI  = 16'hffd9;
    localparam logic [15:0] M_HIGH = 16'hff00;
    localparam logic [15:0] M_FFFF = 16'hffff;

    localparam int TDATA_W = 40;

    // One input byte with its end-of-file flag
    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_file;
    } in_item_t;

    // Result produced by the parser for one byte
    typedef struct packed {
        logic        valid;
        status_t     status;
        logic [15:0] image_width;
        logic [15:0] image_height;
    } result_t;

endpackage

>>> rtl/core/jfs_in_stage.sv
// ----------------------------------------------------------------------------
// jfs_in_stage
// Input register: captures one byte item and holds it until the parser
// advances.
// ----------------------------------------------------------------------------
module jfs_in_stage (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  jfs_pkg::in_item_t s_item,
    input  logic             advance,
    output logic             item_valid,
    output jfs_pkg::in_item_t item
);

    logic              valid_reg;
    logic              valid_next;
    jfs_pkg::in_item_t item_reg;

    // Free when empty or when the held item moves on this cycle
    assign s_tready = !valid_reg || advance;

    always_comb begin
        valid_next = valid_reg;
        if (s_tready) begin
            valid_next = s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

>>> rtl/core/jfs_parser.sv
// ----------------------------------------------------------------------------
// jfs_parser
// Marker walker: updates the parse state for one byte and decides whether
// the byte yields a result.
// ----------------------------------------------------------------------------
module jfs_parser (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              advance,
    input  jfs_pkg::in_item_t item,
    output jfs_pkg::result_t  result
);

    jfs_pkg::phase_t phase_reg, phase_next;
    logic [15:0]     skip_count_reg, skip_count_next;
    logic [7:0]      held_byte_reg, held_byte_next;
    logic [15:0]     held_height_reg, held_height_next;
    logic            is_sof_reg, is_sof_next;
    logic            result_given_reg, result_given_next;

    logic [15:0]     word;
    logic [15:0]     skip_dec;

    assign word     = {held_byte_reg, item.data_byte};
    assign skip_dec = skip_count_reg - 16'd1;

    always_comb begin
        phase_next          = phase_reg;
        skip_count_next     = skip_count_reg;
        held_byte_next      = held_byte_reg;
        held_height_next    = held_height_reg;
        is_sof_next         = is_sof_reg;
        result_given_next   = result_given_reg;
        result.valid        = 1'b0;
        result.status       = jfs_pkg::ST_FOUND;
        result.image_width  = 16'd0;
        result.image_height = 16'd0;

        if (!result_given_reg) begin
            case (phase_reg)
                jfs_pkg::PH_MARK_HI: begin
                    held_byte_next = item.data_byte;
                    phase_next     = jfs_pkg::PH_MARK_LO;
                end
                jfs_pkg::PH_MARK_LO: begin
                    if ((word & jfs_pkg::M_HIGH) != jfs_pkg::M_HIGH) begin
                        result.valid  = 1'b1;
                        result.status = jfs_pkg::ST_BAD_MARK;
                    end else if (word == jfs_pkg::M_EOI) begin
                        result.valid  = 1'b1;
                        result.status = jfs_pkg::ST_EOI;
                    end else if (word == jfs_pkg::M_FFFF) begin
                        // second 0xFF becomes the next marker's high byte
                        held_byte_next = 8'hff;
                    end else if (word == jfs_pkg::M_SOI ||
                                 (word >= jfs_pkg::M_RST0 &&
                                  word <= jfs_pkg::M_RST7)) begin
                        phase_next = jfs_pkg::PH_MARK_HI;
                    end else begin
                        is_sof_next = (word == jfs_pkg::M_SOF0) ||
                                      (word == jfs_pkg::M_SOF2);
                        phase_next  = jfs_pkg::PH_LEN_HI;
                    end
                end
                jfs_pkg::PH_LEN_HI: begin
                    held_byte_next = item.data_byte;
                    phase_next     = jfs_pkg::PH_LEN_LO;
                end
                jfs_pkg::PH_LEN_LO: begin
                    if (word < 16'd2) begin
                        result.valid  = 1'b1;
                        result.status = jfs_pkg::ST_BAD_LEN;
                    end else if (is_sof_reg) begin
                        phase_next = jfs_pkg::PH_PREC;
                    end else if (word == 16'd2) begin
                        phase_next = jfs_pkg::PH_MARK_HI;
                    end else begin
                        skip_count_next = word - 16'd2;
                        phase_next      = jfs_pkg::PH_SKIP;
                    end
                end
                jfs_pkg::PH_SKIP: begin
                    skip_count_next = skip_dec;
                    if (skip_dec == 16'd0) begin
                        phase_next = jfs_pkg::PH_MARK_HI;
                    end
                end
                jfs_pkg::PH_PREC: begin
                    phase_next = jfs_pkg::PH_HGT_HI;
                end
                jfs_pkg::PH_HGT_HI: begin
                    held_byte_next = item.data_byte;
                    phase_next     = jfs_pkg::PH_HGT_LO;
                end
                jfs_pkg::PH_HGT_LO: begin
                    held_height_next = word;
                    phase_next       = jfs_pkg::PH_WID_HI;
                end
                jfs_pkg::PH_WID_HI: begin
                    held_byte_next = item.data_byte;
                    phase_next     = jfs_pkg::PH_WID_LO;
                end
                jfs_pkg::PH_WID_LO: begin
                    result.valid        = 1'b1;
                    result.status       = jfs_pkg::ST_FOUND;
                    result.image_width  = word;
                    result.image_height = held_height_reg;
                end
                default: begin
                    phase_next = jfs_pkg::PH_MARK_HI;
                end
            endcase
            if (result.valid) begin
                result_given_next = 1'b1;
                phase_next        = jfs_pkg::PH_DONE;
            end
        end

        // Last byte of the file: report truncation if nothing was given,
        // then clear for the next file
        if (item.end_of_file) begin
            if (!result_given_reg && !result.valid) begin
                result.valid  = 1'b1;
                result.status = jfs_pkg::ST_TRUNCATED;
            end
            phase_next        = jfs_pkg::PH_MARK_HI;
            skip_count_next   = 16'd0;
            held_byte_next    = 8'd0;
            held_height_next  = 16'd0;
            is_sof_next       = 1'b0;
            result_given_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= jfs_pkg::PH_MARK_HI;
            skip_count_reg   <= 16'd0;
            held_byte_reg    <= 8'd0;
            held_height_reg  <= 16'd0;
            is_sof_reg       <= 1'b0;
            result_given_reg <= 1'b0;
        end else if (advance) begin
            phase_reg        <= phase_next;
            skip_count_reg   <= skip_count_next;
            held_byte_reg    <= held_byte_next;
            held_height_reg  <= held_height_next;
            is_sof_reg       <= is_sof_next;
            result_given_reg <= result_given_next;
        end
    end

endmodule

>>> rtl/core/jfs_out_stage.sv
// ----------------------------------------------------------------------------
// jfs_out_stage
// Result register: holds one result item until the downstream side takes it.
// ----------------------------------------------------------------------------
module jfs_out_stage (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            load,
    input  jfs_pkg::result_t                result,
    output logic                            out_free,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [jfs_pkg::TDATA_W-1:0]     m_tdata
);

    logic             valid_reg, valid_next;
    jfs_pkg::result_t data_reg;

    assign out_free = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (out_free) begin
            valid_next = load && result.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && load && result.valid) begin
            data_reg <= result;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {5'd0, data_reg.image_height, data_reg.image_width,
                       data_reg.status};

endmodule

>>> rtl/core/jpeg_frame_size_scanner.sv
// Path: the byte that causes a result item passes the input register, then
//   the result register, which drives m_tvalid.
// Throughput: one byte per cycle; m_tready low stalls the input only when
//   a result is waiting and the held byte needs the result register.
// Reset: aresetn low (synchronous) empties both registers and returns the
//   parser to expecting a marker high byte.
// ----------------------------------------------------------------------------
// jpeg_frame_size_scanner
// Walks JPEG markers byte by byte and reports the SOF0/SOF2 frame size or
// the reason the scan stopped.
// ----------------------------------------------------------------------------
module jpeg_frame_size_scanner (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,   // [7:0] data_byte
    input  logic                        s_tlast,   // end_of_file
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [jfs_pkg::TDATA_W-1:0] m_tdata    // [2:0] status,
                                                   // [18:3] image_width,
                                                   // [34:19] image_height
);

    jfs_pkg::in_item_t s_item;
    jfs_pkg::in_item_t item;
    jfs_pkg::result_t  result;
    logic              item_valid;
    logic              out_free;
    logic              advance;

    assign s_item.data_byte   = s_tdata;
    assign s_item.end_of_file = s_tlast;

    // Move the held byte through the parser unless its result would land
    // on a result item that is still waiting
    assign advance = item_valid && (out_free || !result.valid);

    jfs_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_item     (s_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    jfs_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (item),
        .result  (result)
    );

    jfs_out_stage u_out_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (advance),
        .result   (result),
        .out_free (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

>>> sim/tb_jpeg_frame_size_scanner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_jpeg_frame_size_scanner
// Streams JPEG-like byte files into the scanner with random gaps on both
// sides. The bench predicts each file's frame size or stop reason and
// compares every result item against it, field by field.
// ----------------------------------------------------------------------------
module tb_jpeg_frame_size_scanner;
    import jfs_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int LONG_HOLD   = 400;
    localparam int BYTE_TARGET = 1424;

    typedef struct {
        status_t     status;
        logic [15:0] width;
        logic [15:0] height;
    } frame_size_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata  = 8'h00;
    logic                 s_tlast  = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [TDATA_W-1:0]   m_tdata;

    in_item_t    pending_bytes[$];
    logic [7:0]  file_buf[$];
    frame_size_t expected_sizes[$];

    // Scanner shadow state
    phase_t      scan_phase   = PH_MARK_HI;
    logic [15:0] skip_left    = '0;
    logic [7:0]  held         = '0;
    logic [15:0] frame_height = '0;
    logic        in_sof       = 1'b0;
    logic        file_done    = 1'b0;

    int  send_gap     = 0;
    bit  send_steady  = 1'b0;
    int  rcv_wait     = 0;
    bit  rcv_steady   = 1'b0;
    int  results_seen = 0;
    int  quiet_cycles = 0;
    int  error_count  = 0;

    jpeg_frame_size_scanner u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Advance the shadow scanner by one accepted byte; queue any result.
    task automatic scan_byte(input logic [7:0] b, input logic last);
        logic [15:0] word;
        logic        hit;
        frame_size_t r;
        word = {held, b};
        hit  = 1'b0;
        r.status = ST_FOUND;
        r.width  = '0;
        r.height = '0;
        if (!file_done) begin
            case (scan_phase)
                PH_MARK_HI: begin
                    held       = b;
                    scan_phase = PH_MARK_LO;
                end
                PH_MARK_LO: begin
                    if ((word & M_HIGH) != M_HIGH) begin
                        r.status = ST_BAD_MARK;
                        hit      = 1'b1;
                    end else if (word == M_EOI) begin
                        r.status = ST_EOI;
                        hit      = 1'b1;
                    end else if (word == M_FFFF) begin
                        // second 0xFF is the next marker's high byte
                        held = 8'hff;
                    end else if (word == M_SOI || (word >= M_RST0 && word <= M_RST7)) begin
                        scan_phase = PH_MARK_HI;
                    end else begin
                        in_sof     = (word == M_SOF0 || word == M_SOF2);
                        scan_phase = PH_LEN_HI;
                    end
                end
                PH_LEN_HI: begin
                    held       = b;
                    scan_phase = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    if (word < 16'd2) begin
                        r.status = ST_BAD_LEN;
                        hit      = 1'b1;
                    end else if (in_sof) begin
                        scan_phase = PH_PREC;
                    end else if (word == 16'd2) begin
                        scan_phase = PH_MARK_HI;
                    end else begin
                        skip_left  = word - 16'd2;
                        scan_phase = PH_SKIP;
                    end
                end
                PH_SKIP: begin
                    skip_left = skip_left - 16'd1;
                    if (skip_left == 16'd0) scan_phase = PH_MARK_HI;
                end
                PH_PREC:   scan_phase = PH_HGT_HI;
                PH_HGT_HI: begin
                    held       = b;
                    scan_phase = PH_HGT_LO;
                end
                PH_HGT_LO: begin
                    frame_height = word;
                    scan_phase   = PH_WID_HI;
                end
                PH_WID_HI: begin
                    held       = b;
                    scan_phase = PH_WID_LO;
                end
                PH_WID_LO: begin
                    r.width  = word;
                    r.height = frame_height;
                    hit      = 1'b1;
                end
                default:   scan_phase = PH_MARK_HI;
            endcase
            if (hit) begin
                file_done  = 1'b1;
                scan_phase = PH_DONE;
            end
        end
        if (last) begin
            if (!file_done) begin
                r.status = ST_TRUNCATED;
                hit      = 1'b1;
            end
            scan_phase   = PH_MARK_HI;
            skip_left    = '0;
            held         = '0;
            frame_height = '0;
            in_sof       = 1'b0;
            file_done    = 1'b0;
        end
        if (hit) expected_sizes.push_back(r);
    endtask

    // Move the file buffer into the send queue, flagging its final byte.
    task automatic flush_file();
        in_item_t it;
        for (int i = 0; i < file_buf.size(); i++) begin
            it.data_byte   = file_buf[i];
            it.end_of_file = (i == file_buf.size() - 1);
            pending_bytes.push_back(it);
        end
        file_buf.delete();
    endtask

    // Marker low byte that opens a plain, length-carrying segment
    function automatic logic [7:0] plain_code();
        logic [7:0] c;
        do begin
            c = 8'($urandom_range(0, 254));
        end while (c == M_SOF0[7:0] || c == M_SOF2[7:0] || c == M_SOI[7:0] ||
                   c == M_EOI[7:0] || (c >= M_RST0[7:0] && c <= M_RST7[7:0]));
        return c;
    endfunction

    task automatic build_random_file();
        int          kind;
        int          seglen;
        int          cut;
        int          pick;
        logic [15:0] len;
        kind = $urandom_range(0, 9);
        if (kind <= 6 || kind == 8) begin
            if ($urandom_range(0, 3) != 0) begin
                file_buf.push_back(M_SOI[15:8]);
                file_buf.push_back(M_SOI[7:0]);
            end
            repeat ($urandom_range(0, 3)) begin
                if ($urandom_range(0, 3) == 0) begin
                    file_buf.push_back(8'hff);
                    file_buf.push_back(M_RST0[7:0] + 8'($urandom_range(0, 7)));
                end else begin
                    repeat ($urandom_range(0, 1)) file_buf.push_back(8'hff);
                    file_buf.push_back(8'hff);
                    file_buf.push_back(plain_code());
                    seglen = $urandom_range(2, 8);
                    file_buf.push_back(8'h00);
                    file_buf.push_back(8'(seglen));
                    repeat (seglen - 2) file_buf.push_back(8'($urandom));
                end
            end
            if (kind == 8) begin
                pick = $urandom_range(0, 2);
                if (pick == 0) begin
                    file_buf.push_back(M_EOI[15:8]);
                    file_buf.push_back(M_EOI[7:0]);
                end else if (pick == 1) begin
                    file_buf.push_back(8'hff);
                    file_buf.push_back(plain_code());
                    file_buf.push_back(8'h00);
                    file_buf.push_back(8'($urandom_range(0, 1)));
                end else begin
                    file_buf.push_back(8'($urandom_range(0, 254)));
                    file_buf.push_back(8'($urandom));
                end
            end else begin
                file_buf.push_back(8'hff);
                file_buf.push_back($urandom_range(0, 1) ? M_SOF0[7:0] : M_SOF2[7:0]);
                len = 16'($urandom_range(2, 65535));
                file_buf.push_back(len[15:8]);
                file_buf.push_back(len[7:0]);
                repeat (5) file_buf.push_back(8'($urandom));
            end
            repeat ($urandom_range(0, 3)) file_buf.push_back(8'($urandom));
            if (kind == 6) begin
                cut = $urandom_range(1, file_buf.size());
                while (file_buf.size() > cut) void'(file_buf.pop_back());
            end
        end else if (kind == 7) begin
            repeat ($urandom_range(1, 12))
                file_buf.push_back($urandom_range(0, 1) ? 8'hff : 8'($urandom));
        end else begin
            // random 16-bit segment length, file may end before the skip does
            file_buf.push_back(M_SOI[15:8]);
            file_buf.push_back(M_SOI[7:0]);
            file_buf.push_back(8'hff);
            file_buf.push_back(plain_code());
            len = 16'($urandom);
            file_buf.push_back(len[15:8]);
            file_buf.push_back(len[7:0]);
            repeat ($urandom_range(0, 6)) file_buf.push_back(8'($urandom));
        end
        flush_file();
    endtask

    initial begin
        // SOI, RST3, 0xFFFF fill, SOF2 with minimal length, extreme sizes
        file_buf = '{8'hff, 8'hd8, 8'hff, 8'hd3, 8'hff, 8'hff, 8'hc2,
                     8'h00, 8'h02, 8'h00, 8'hff, 8'hff, 8'h00, 8'h00};
        flush_file();
        // single byte: truncated
        file_buf = '{8'h12};
        flush_file();
        // bad marker high byte
        file_buf = '{8'h12, 8'h34};
        flush_file();
        // EOI, then a byte that must be ignored
        file_buf = '{8'hff, 8'hd9, 8'h55};
        flush_file();
        // length below two
        file_buf = '{8'hff, 8'he0, 8'h00, 8'h01};
        flush_file();
        while (pending_bytes.size() < BYTE_TARGET) build_random_file();

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_bytes.size() != 0 || s_tvalid || expected_sizes.size() != 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Byte driver
    always @(posedge aclk) begin
        in_item_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'h00;
            s_tlast  <= 1'b0;
            send_gap = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                scan_byte(s_tdata, s_tlast);
                if ($urandom_range(0, 49) == 0) send_steady = !send_steady;
                send_gap = send_steady ? 0 : $urandom_range(0, 3);
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap == 0 && pending_bytes.size() != 0) begin
                    nxt = pending_bytes.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= nxt.data_byte;
                    s_tlast  <= nxt.end_of_file;
                end else begin
                    s_tvalid <= 1'b0;
                    if (send_gap != 0) send_gap--;
                end
            end
        end
    end

    // Result monitor and receiver back-pressure
    always @(posedge aclk) begin
        frame_size_t exp_size;
        if (!aresetn) begin
            m_tready <= 1'b0;
            rcv_wait = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_sizes.size() == 0) begin
                    $error("unexpected result item: status %0d width %0d height %0d",
                           m_tdata[2:0], m_tdata[18:3], m_tdata[34:19]);
                    error_count++;
                end else begin
                    exp_size = expected_sizes.pop_front();
                    if (m_tdata[2:0] != exp_size.status) begin
                        $error("status: expected %0d, got %0d", exp_size.status, m_tdata[2:0]);
                        error_count++;
                    end
                    if (m_tdata[18:3] != exp_size.width) begin
                        $error("image_width: expected %0d, got %0d",
                               exp_size.width, m_tdata[18:3]);
                        error_count++;
                    end
                    if (m_tdata[34:19] != exp_size.height) begin
                        $error("image_height: expected %0d, got %0d",
                               exp_size.height, m_tdata[34:19]);
                        error_count++;
                    end
                end
                results_seen++;
                // hold off once for long enough to back the block up
                if (results_seen == 30) begin
                    rcv_wait = LONG_HOLD;
                end else begin
                    if ($urandom_range(0, 9) == 0) rcv_steady = !rcv_steady;
                    rcv_wait = rcv_steady ? 0 : $urandom_range(0, 3);
                end
            end else if (rcv_wait != 0) begin
                rcv_wait--;
            end
            m_tready <= (rcv_wait == 0);
        end
    end

    // Watchdog on handshake progress
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

endmodule

>>> sim.f
rtl/core/jfs_pkg.sv
rtl/core/jfs_in_stage.sv
rtl/core/jfs_parser.sv
rtl/core/jfs_out_stage.sv
rtl/core/jpeg_frame_size_scanner.sv
sim/tb_jpeg_frame_size_scanner.sv
